// ===== rtl/jdow_pkg.sv =====
// Shared types, widths and constants for the Jalali day-of-week block.
// Used by the configuration bank, the ordinal unit and the top level.
package jdow_pkg;

  localparam int YEAR_W     = 11;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int WDAY_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int ORD_W      = 11;
  localparam int PREFIX_W   = 9;
  localparam int SPAN_W     = 9;
  localparam int CYCLE_W    = 4;
  localparam int REM_W      = 6;
  localparam int RECIP_W    = 10;
  localparam int RECIP_SHIFT = 14;
  localparam int MOD7_W     = 13;
  localparam int MOD7_SHIFT = 15;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 11'd1600;
  localparam logic [YEAR_W-1:0]  LEAP_FIRST = 11'd1310;
  localparam logic [RECIP_W-1:0] RECIP_33   = 10'd497;
  localparam logic [MOD7_W-1:0]  RECIP_7    = 13'd4682;
  localparam logic [REM_W-1:0]   REM_FULL   = 6'd28;
  localparam logic [WDAY_W-1:0]  PART_FULL  = 3'd7;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [WDAY_W-1:0]  WEEK_LEN   = 3'd7;

  localparam logic [YEAR_W-1:0]  RST_REF_YEAR    = 11'd1395;
  localparam logic [MONTH_W-1:0] RST_REF_MONTH   = 4'd9;
  localparam logic [DAY_W-1:0]   RST_REF_DAY     = 5'd1;
  localparam logic [WDAY_W-1:0]  RST_REF_WEEKDAY = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_YEAR    = 2'd0,
    REG_REF_MONTH   = 2'd1,
    REG_REF_DAY     = 2'd2,
    REG_REF_WEEKDAY = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
  } ref_t;

  function automatic logic [PREFIX_W-1:0] month_prefix(input logic [MONTH_W-1:0] m);
    logic [PREFIX_W-1:0] p;
    case (m)
      4'd1:    p = 9'd0;
      4'd2:    p = 9'd31;
      4'd3:    p = 9'd62;
      4'd4:    p = 9'd93;
      4'd5:    p = 9'd124;
      4'd6:    p = 9'd155;
      4'd7:    p = 9'd186;
      4'd8:    p = 9'd216;
      4'd9:    p = 9'd246;
      4'd10:   p = 9'd276;
      4'd11:   p = 9'd306;
      4'd12:   p = 9'd336;
      default: p = 9'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/jdow_cfg.sv =====
// Reference date register bank with a plain write port.
// Depends on jdow_pkg.
module jdow_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [jdow_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdow_pkg::CFG_DATA_W-1:0] cfg_data,
  output jdow_pkg::ref_t                  ref_date
);

  jdow_pkg::ref_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.year    <= jdow_pkg::RST_REF_YEAR;
      regs.month   <= jdow_pkg::RST_REF_MONTH;
      regs.day     <= jdow_pkg::RST_REF_DAY;
      regs.weekday <= jdow_pkg::RST_REF_WEEKDAY;
    end else if (cfg_wr_en) begin
      case (jdow_pkg::cfg_reg_t'(cfg_index))
        jdow_pkg::REG_REF_YEAR:    regs.year    <= cfg_data[jdow_pkg::YEAR_W-1:0];
        jdow_pkg::REG_REF_MONTH:   regs.month   <= cfg_data[jdow_pkg::MONTH_W-1:0];
        jdow_pkg::REG_REF_DAY:     regs.day     <= cfg_data[jdow_pkg::DAY_W-1:0];
        jdow_pkg::REG_REF_WEEKDAY: regs.weekday <= cfg_data[jdow_pkg::WDAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign ref_date = regs;

endmodule

// ===== rtl/jdow_ordinal.sv =====
// Day ordinal of a Jalali date, reduced to a value congruent modulo 7.
// Depends on jdow_pkg for widths, the month table and the leap constants.
module jdow_ordinal (
  input  logic [jdow_pkg::YEAR_W-1:0]  year,
  input  logic [jdow_pkg::MONTH_W-1:0] month,
  input  logic [jdow_pkg::DAY_W-1:0]   day,
  output logic [jdow_pkg::ORD_W-1:0]   ord_sum
);

  logic [jdow_pkg::YEAR_W-1:0]             y_sat;
  logic [jdow_pkg::SPAN_W-1:0]             span;
  logic [jdow_pkg::SPAN_W+jdow_pkg::RECIP_W-1:0] prod;
  logic [jdow_pkg::CYCLE_W-1:0]            cycles;
  logic [jdow_pkg::SPAN_W-1:0]             cycle_days;
  logic [jdow_pkg::REM_W-1:0]              rem;
  logic [jdow_pkg::WDAY_W-1:0]             partial;
  logic [jdow_pkg::MONTH_W-1:0]            m_clamp;

  // 365 is 1 mod 7 and each 33-year cycle holds 8 leap years, also 1 mod 7
  always_comb begin
    y_sat      = (year > jdow_pkg::MAX_YEAR) ? jdow_pkg::MAX_YEAR : year;
    span       = (y_sat > jdow_pkg::LEAP_FIRST) ?
                 jdow_pkg::SPAN_W'(y_sat - jdow_pkg::LEAP_FIRST) : '0;
    prod       = jdow_pkg::SPAN_W'(span) * jdow_pkg::RECIP_33;
    cycles     = jdow_pkg::CYCLE_W'(prod >> jdow_pkg::RECIP_SHIFT);
    cycle_days = {cycles, 5'b0} + jdow_pkg::SPAN_W'(cycles);
    rem        = jdow_pkg::REM_W'(span - cycle_days);
    partial    = (rem >= jdow_pkg::REM_FULL) ? jdow_pkg::PART_FULL : rem[4:2];
    if (month < jdow_pkg::MONTH_FIRST)
      m_clamp = jdow_pkg::MONTH_FIRST;
    else if (month > jdow_pkg::MONTH_LAST)
      m_clamp = jdow_pkg::MONTH_LAST;
    else
      m_clamp = month;
    ord_sum = jdow_pkg::ORD_W'(y_sat)
            + jdow_pkg::ORD_W'(cycles)
            + jdow_pkg::ORD_W'(partial)
            + jdow_pkg::ORD_W'(jdow_pkg::month_prefix(m_clamp))
            + jdow_pkg::ORD_W'(day);
  end

endmodule

// ===== rtl/jalali_day_of_week.sv =====
// Jalali day-of-week: top level with the three-register pipeline.
// Stages: the query is registered in the input stage, both ordinals in the middle stage, the weekday at the output.
// Throughput: one query per cycle while weekday_stall is low; the output register and stall chain set it.
// Reset: rst clears all valid flags and loads the reference date 1395/9/1, weekday 2.
// Depends on jdow_pkg, jdow_cfg and jdow_ordinal.
module jalali_day_of_week (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [jdow_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdow_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            query_valid,
  output logic                            query_stall,
  input  logic [jdow_pkg::YEAR_W-1:0]     query_year,
  input  logic [jdow_pkg::MONTH_W-1:0]    query_month,
  input  logic [jdow_pkg::DAY_W-1:0]      query_day,
  output logic                            weekday_valid,
  input  logic                            weekday_stall,
  output logic [jdow_pkg::WDAY_W-1:0]     weekday
);

  function automatic logic [jdow_pkg::WDAY_W-1:0] mod7(input logic [jdow_pkg::ORD_W-1:0] x);
    logic [jdow_pkg::ORD_W+jdow_pkg::MOD7_W-1:0] p;
    logic [jdow_pkg::ORD_W-1:0]                  q;
    p = jdow_pkg::ORD_W'(x) * jdow_pkg::RECIP_7;
    q = jdow_pkg::ORD_W'(p >> jdow_pkg::MOD7_SHIFT);
    return jdow_pkg::WDAY_W'(x - jdow_pkg::ORD_W'({q, 3'b000} - q));
  endfunction

  jdow_pkg::ref_t ref_date;

  logic                           in_v;
  logic [jdow_pkg::YEAR_W-1:0]    in_year;
  logic [jdow_pkg::MONTH_W-1:0]   in_month;
  logic [jdow_pkg::DAY_W-1:0]     in_day;

  logic                           mid_v;
  logic [jdow_pkg::ORD_W-1:0]     mid_qord;
  logic [jdow_pkg::ORD_W-1:0]     mid_rord;

  logic                           out_v;
  logic [jdow_pkg::WDAY_W-1:0]    out_wday;

  logic [jdow_pkg::ORD_W-1:0]     q_ord;
  logic [jdow_pkg::ORD_W-1:0]     r_ord;
  logic [jdow_pkg::WDAY_W-1:0]    q_res;
  logic [jdow_pkg::WDAY_W-1:0]    r_res;
  logic [jdow_pkg::WDAY_W-1:0]    base_wday;
  logic [4:0]                     wsum;
  logic [jdow_pkg::WDAY_W-1:0]    wday_next;

  logic ready_out;
  logic ready_mid;
  logic ready_in;

  jdow_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ref_date  (ref_date)
  );

  jdow_ordinal u_query_ord (
    .year    (in_year),
    .month   (in_month),
    .day     (in_day),
    .ord_sum (q_ord)
  );

  jdow_ordinal u_ref_ord (
    .year    (ref_date.year),
    .month   (ref_date.month),
    .day     (ref_date.day),
    .ord_sum (r_ord)
  );

  assign ready_out   = !out_v || !weekday_stall;
  assign ready_mid   = !mid_v || ready_out;
  assign ready_in    = !in_v || ready_mid;
  assign query_stall = !ready_in;

  always_comb begin
    q_res     = mod7(mid_qord);
    r_res     = mod7(mid_rord);
    base_wday = (ref_date.weekday == jdow_pkg::WEEK_LEN) ? '0 : ref_date.weekday;
    wsum      = 5'(base_wday) + 5'(q_res) + 5'(jdow_pkg::WEEK_LEN) - 5'(r_res);
    if (wsum >= 5'(2 * jdow_pkg::WEEK_LEN))
      wday_next = jdow_pkg::WDAY_W'(wsum - 5'(2 * jdow_pkg::WEEK_LEN));
    else if (wsum >= 5'(jdow_pkg::WEEK_LEN))
      wday_next = jdow_pkg::WDAY_W'(wsum - 5'(jdow_pkg::WEEK_LEN));
    else
      wday_next = jdow_pkg::WDAY_W'(wsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      mid_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (ready_in)  in_v  <= query_valid;
      if (ready_mid) mid_v <= in_v;
      if (ready_out) out_v <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && query_valid) begin
      in_year  <= query_year;
      in_month <= query_month;
      in_day   <= query_day;
    end
    if (ready_mid && in_v) begin
      mid_qord <= q_ord;
      mid_rord <= r_ord;
    end
    if (ready_out && mid_v) begin
      out_wday <= wday_next;
    end
  end

  assign weekday_valid = out_v;
  assign weekday       = out_wday;

endmodule

// ===== rtl/jdow_checker.sv =====
// Port-level checks for the Jalali day-of-week block, bound to the top level.
// Depends on jdow_pkg and jalali_day_of_week.
module jdow_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        query_valid,
  input logic                        query_stall,
  input logic                        weekday_valid,
  input logic                        weekday_stall,
  input logic [jdow_pkg::WDAY_W-1:0] weekday
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !weekday_valid)
    else $error("result valid after reset");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    weekday_valid |-> weekday != jdow_pkg::WEEK_LEN)
    else $error("weekday out of range");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    !weekday_stall |-> !query_stall)
    else $error("query stalled while result side is free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    query_valid && !query_stall ##1 !weekday_stall ##1 !weekday_stall |=> weekday_valid)
    else $error("result missing three cycles after transaction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    weekday_valid && weekday_stall |=> weekday_valid && $stable(weekday))
    else $error("stalled result changed");

endmodule

bind jalali_day_of_week jdow_checker u_jdow_checker (
  .clk           (clk),
  .rst           (rst),
  .query_valid   (query_valid),
  .query_stall   (query_stall),
  .weekday_valid (weekday_valid),
  .weekday_stall (weekday_stall),
  .weekday       (weekday)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for jalali_day_of_week: random and directed date queries under several references.
// Predicts each weekday from a day count, checks results in order; needs jdow_pkg and the RTL.
module tb;

  typedef struct packed {
    logic [jdow_pkg::YEAR_W-1:0]  year;
    logic [jdow_pkg::MONTH_W-1:0] month;
    logic [jdow_pkg::DAY_W-1:0]   day;
  } date_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [jdow_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jdow_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            query_valid = 1'b0;
  logic                            query_stall;
  logic [jdow_pkg::YEAR_W-1:0]     query_year = '0;
  logic [jdow_pkg::MONTH_W-1:0]    query_month = '0;
  logic [jdow_pkg::DAY_W-1:0]      query_day = '0;
  logic                            weekday_valid;
  logic                            weekday_stall = 1'b0;
  logic [jdow_pkg::WDAY_W-1:0]     weekday;

  logic [jdow_pkg::YEAR_W-1:0]  cal_year = jdow_pkg::RST_REF_YEAR;
  logic [jdow_pkg::MONTH_W-1:0] cal_month = jdow_pkg::RST_REF_MONTH;
  logic [jdow_pkg::DAY_W-1:0]   cal_day = jdow_pkg::RST_REF_DAY;
  logic [jdow_pkg::WDAY_W-1:0]  cal_wday = jdow_pkg::RST_REF_WEEKDAY;

  date_t                       dates_pending[$];
  logic [jdow_pkg::WDAY_W-1:0] weekdays_due[$];
  logic                        calm = 1'b0;
  int                          errors = 0;

  jalali_day_of_week i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query_year   (query_year),
    .query_month  (query_month),
    .query_day    (query_day),
    .weekday_valid(weekday_valid),
    .weekday_stall(weekday_stall),
    .weekday      (weekday)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap_year(int y);
    int r;
    if (y <= 1309) begin
      return 1'b0;
    end
    r = (y - 1309) % 33;
    return (r % 4 == 0) && (r <= 28);
  endfunction

  function automatic int day_number(logic [jdow_pkg::YEAR_W-1:0] y_in,
                                    logic [jdow_pkg::MONTH_W-1:0] m_in,
                                    logic [jdow_pkg::DAY_W-1:0] d);
    int y;
    int m;
    int total;
    y = (y_in > jdow_pkg::MAX_YEAR) ? int'(jdow_pkg::MAX_YEAR) : int'(y_in);
    m = (m_in < 1) ? 1 : (m_in > 12) ? 12 : int'(m_in);
    total = y * 365;
    for (int i = 1310; i < y; i++) begin
      if (is_leap_year(i)) begin
        total++;
      end
    end
    total += (m <= 7) ? (m - 1) * 31 : 186 + (m - 7) * 30;
    return total + int'(d);
  endfunction

  function automatic logic [jdow_pkg::WDAY_W-1:0] predict_weekday(date_t q);
    int diff;
    int w;
    diff = day_number(q.year, q.month, q.day) - day_number(cal_year, cal_month, cal_day);
    w = (int'(cal_wday) + diff % 7) % 7;
    if (w < 0) begin
      w += 7;
    end
    return w[jdow_pkg::WDAY_W-1:0];
  endfunction

  function automatic date_t random_date(int noise_pct);
    date_t q;
    int len;
    if ($urandom_range(0, 99) < noise_pct) begin
      q.year = jdow_pkg::YEAR_W'($urandom_range(0, 2047));
      q.month = jdow_pkg::MONTH_W'($urandom_range(0, 15));
      q.day = jdow_pkg::DAY_W'($urandom_range(0, 31));
    end else begin
      q.year = jdow_pkg::YEAR_W'($urandom_range(1310, 1600));
      q.month = jdow_pkg::MONTH_W'($urandom_range(1, 12));
      len = (q.month <= 6) ? 31 : (q.month <= 11) ? 30 :
            (is_leap_year(int'(q.year)) ? 30 : 29);
      q.day = jdow_pkg::DAY_W'($urandom_range(1, len));
    end
    return q;
  endfunction

  // driver
  always @(posedge clk) begin
    date_t q;
    if (rst) begin
      query_valid <= 1'b0;
    end else begin
      if (query_valid && !query_stall) begin
        weekdays_due.push_back(predict_weekday('{query_year, query_month, query_day}));
      end
      if (!query_valid || !query_stall) begin
        if (dates_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          q = dates_pending.pop_front();
          query_valid <= 1'b1;
          query_year <= q.year;
          query_month <= q.month;
          query_day <= q.day;
        end else begin
          query_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [jdow_pkg::WDAY_W-1:0] want;
    if (rst) begin
      weekday_stall <= 1'b0;
    end else begin
      if (weekday_valid && !weekday_stall) begin
        if (weekdays_due.size() == 0) begin
          $error("weekday: unexpected transaction, got %0d", weekday);
          errors++;
        end else begin
          want = weekdays_due.pop_front();
          if (weekday !== want) begin
            $error("weekday: expected %0d, got %0d", want, weekday);
            errors++;
          end
        end
      end
      weekday_stall <= !calm && ($urandom_range(0, 99) < 13);
    end
  end

  task automatic write_reg(input jdow_pkg::cfg_reg_t idx,
                           input logic [jdow_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      jdow_pkg::REG_REF_YEAR:    cal_year = val[jdow_pkg::YEAR_W-1:0];
      jdow_pkg::REG_REF_MONTH:   cal_month = val[jdow_pkg::MONTH_W-1:0];
      jdow_pkg::REG_REF_DAY:     cal_day = val[jdow_pkg::DAY_W-1:0];
      jdow_pkg::REG_REF_WEEKDAY: cal_wday = val[jdow_pkg::WDAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_reference(input int y, input int m, input int d, input int w);
    write_reg(jdow_pkg::REG_REF_YEAR, jdow_pkg::CFG_DATA_W'(y));
    write_reg(jdow_pkg::REG_REF_MONTH, jdow_pkg::CFG_DATA_W'(m));
    write_reg(jdow_pkg::REG_REF_DAY, jdow_pkg::CFG_DATA_W'(d));
    write_reg(jdow_pkg::REG_REF_WEEKDAY, jdow_pkg::CFG_DATA_W'(w));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int n, input int noise_pct);
    @(negedge clk);
    repeat (n) dates_pending.push_back(random_date(noise_pct));
  endtask

  task automatic drain();
    @(negedge clk);
    while (dates_pending.size() != 0 || query_valid || weekdays_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin
    date_t directed[$];
    directed = '{
      '{11'd1395, 4'd9, 5'd1}, '{11'd1310, 4'd1, 5'd1}, '{11'd1600, 4'd12, 5'd29},
      '{11'd1600, 4'd12, 5'd30}, '{11'd1399, 4'd12, 5'd30}, '{11'd1403, 4'd12, 5'd30},
      '{11'd1404, 4'd1, 5'd1}, '{11'd1309, 4'd12, 5'd29}, '{11'd0, 4'd0, 5'd0},
      '{11'd2047, 4'd15, 5'd31}, '{11'd1601, 4'd1, 5'd1}, '{11'd1500, 4'd13, 5'd5},
      '{11'd1450, 4'd0, 5'd0}, '{11'd1350, 4'd6, 5'd31}, '{11'd1350, 4'd7, 5'd30},
      '{11'd1350, 4'd11, 5'd30}, '{11'd1350, 4'd7, 5'd31}, '{11'd1395, 4'd8, 5'd30},
      '{11'd1395, 4'd9, 5'd0}, '{11'd1024, 4'd5, 5'd16}, '{11'd1395, 4'd9, 5'd31}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (directed[i]) dates_pending.push_back(directed[i]);
    run_random(80, 15);
    drain();

    set_reference(1310, 1, 1, 0);
    run_random(110, 10);
    drain();

    set_reference(1600, 12, 30, 6);
    @(negedge clk);
    calm = 1'b1;
    run_random(110, 10);
    drain();
    @(negedge clk);
    calm = 1'b0;

    set_reference(2047, 15, 31, 7);
    run_random(100, 30);
    drain();

    set_reference(0, 0, 0, 0);
    run_random(90, 15);
    drain();

    set_reference($urandom_range(1310, 1600), $urandom_range(1, 12), $urandom_range(1, 29),
                  $urandom_range(0, 6));
    run_random(110, 10);
    drain();

    set_reference($urandom_range(0, 2047), $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(0, 7));
    run_random(100, 25);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jdow_pkg.sv
rtl/jdow_cfg.sv
rtl/jdow_ordinal.sv
rtl/jalali_day_of_week.sv
rtl/jdow_checker.sv
test/tb.sv
